// ===== hdl/lmsar_pkg.sv =====
package lmsar_pkg;

    // tap weights, signed Q4.28
    localparam int W_BITS  = 32;
    localparam int W_FRAC  = 28;
    localparam logic signed [W_BITS-1:0] W_MAX = {1'b0, {(W_BITS-1){1'b1}}};
    localparam logic signed [W_BITS-1:0] W_MIN = {1'b1, {(W_BITS-1){1'b0}}};

    // error times sample, brought to 30 fraction bits
    localparam int EX_FRAC = 30;
    localparam int EX30_W  = 33;

    // step size, unsigned Q0.24
    localparam int MU_BITS      = 24;
    localparam int MU_RND_SHIFT = 25;

    // step size decay, mu = floor((mu * 100 + 50) / 101)
    localparam int DEC_MUL   = 100;
    localparam int DEC_ADD   = 50;
    localparam int DEC_DIV   = 101;
    localparam int DEC_NUM_W = 31;
    localparam int DEC_SHIFT = 38;
    localparam int DEC_REM_W = 8;
    localparam logic [31:0] DEC_RECIP = 32'd2721563435;

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DECAY_W    = 16;
    localparam int TAPS_W     = 5;
    localparam int PIDX_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS      = 2'd2;

    localparam logic [MU_BITS-1:0] STEP_RST  = 24'd167772;
    localparam logic [DECAY_W-1:0] DECAY_RST = 16'd100;
    localparam logic [TAPS_W-1:0]  TAPS_RST  = 5'd16;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_INSERT
    } t_cell_op;

endpackage

// ===== hdl/lmsar_cell.sv =====
module lmsar_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lmsar_pkg::t_cell_op                 i_op,
    input  logic signed [SAMPLE_BITS-1:0]       i_next_x,
    input  logic signed [lmsar_pkg::W_BITS-1:0] i_next_w,
    input  logic signed [SAMPLE_BITS-1:0]       i_prev_x,
    output logic signed [SAMPLE_BITS-1:0]       o_x,
    output logic signed [lmsar_pkg::W_BITS-1:0] o_w
);

    logic signed [SAMPLE_BITS-1:0]       r_x;
    logic signed [lmsar_pkg::W_BITS-1:0] r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_w <= '0;
        end else begin
            unique case (i_op)
                lmsar_pkg::CELL_HOLD: begin
                    r_x <= r_x;
                end
                lmsar_pkg::CELL_ROTATE: begin
                    r_x <= i_next_x;
                    r_w <= i_next_w;
                end
                lmsar_pkg::CELL_INSERT: begin
                    r_x <= i_prev_x;
                end
                default: begin
                    r_x <= r_x;
                end
            endcase
        end
    end

    assign o_x = r_x;
    assign o_w = r_w;

endmodule

// ===== hdl/lmsar_decay.sv =====
module lmsar_decay (
    input  logic                            i_clk,
    input  logic [lmsar_pkg::MU_BITS-1:0]   i_mu,
    output logic [lmsar_pkg::MU_BITS-1:0]   o_mu
);

    localparam int NW = lmsar_pkg::DEC_NUM_W;
    localparam int PW = NW + 32;

    logic [NW-1:0]                      r_num;
    logic [NW-1:0]                      r_num_d;
    logic [PW-1:0]                      r_prod;
    logic [lmsar_pkg::MU_BITS-1:0]      r_q0;
    logic [lmsar_pkg::DEC_REM_W-1:0]    r_rem;
    logic [lmsar_pkg::MU_BITS-1:0]      r_mu;
    logic [lmsar_pkg::MU_BITS-1:0]      q0;
    logic [NW-1:0]                      rem;

    // reciprocal estimate is low by at most one
    assign q0  = r_prod[lmsar_pkg::DEC_SHIFT +: lmsar_pkg::MU_BITS];
    assign rem = r_num_d - NW'(q0) * NW'(lmsar_pkg::DEC_DIV);

    always_ff @(posedge i_clk) begin
        r_num   <= NW'(i_mu) * NW'(lmsar_pkg::DEC_MUL) + NW'(lmsar_pkg::DEC_ADD);
        r_prod  <= PW'(r_num) * PW'(lmsar_pkg::DEC_RECIP);
        r_num_d <= r_num;
        r_q0    <= q0;
        r_rem   <= rem[lmsar_pkg::DEC_REM_W-1:0];
        r_mu    <= (r_rem >= lmsar_pkg::DEC_REM_W'(lmsar_pkg::DEC_DIV)) ?
                   r_q0 + lmsar_pkg::MU_BITS'(1) : r_q0;
    end

    assign o_mu = r_mu;

endmodule

// ===== hdl/lms_autoregressive_predictor_top.sv =====
// LMS one-step linear predictor. Each sample transferred in on s_axis is predicted from the
// taps_in_use samples before it in the current training pass (tuser marks the first sample of
// a pass); once the pass holds that many samples the result carries the rounded, saturated
// prediction, the error and adapted = 1, and the tap weights move by 2*mu*e*x, otherwise all
// result fields are zero. The weights and past samples live in a row of MAX_TAPS cells that
// rotate through a shared multiply-accumulate and update pipeline: an adapting sample makes one
// rotation for the dot product and one rotation through the two-stage update pipeline, while
// any other sample goes straight to its result. One result per sample, held in an output
// register while the next sample is taken in. The step size restarts from register 0 when it
// is written and is divided by 1.01 on adapting samples at the start of each decay cycle.
module lms_autoregressive_predictor_top #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]            s_axis_tdata,   // sample
    input  logic [0:0]                                  s_axis_tuser,   // pass_start
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic [((2*SAMPLE_BITS+1+7)/8)*8-1:0]        m_axis_tdata,   // prediction, error
    output logic [0:0]                                  m_axis_tuser,   // adapted
    input  logic                                        i_cfg_we,
    input  logic [lmsar_pkg::CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [lmsar_pkg::CFG_DATA_W-1:0]            i_cfg_data
);

    localparam int S      = SAMPLE_BITS;
    localparam int WB     = lmsar_pkg::W_BITS;
    localparam int OUT_W  = ((2*S+1+7)/8)*8;
    localparam int CNT_W  = $clog2(MAX_TAPS + 2);
    localparam int CW     = (CNT_W > lmsar_pkg::TAPS_W) ? CNT_W : lmsar_pkg::TAPS_W;
    localparam int PR_W   = WB + S;
    localparam int ACC_W  = PR_W + $clog2(MAX_TAPS) + 1;
    localparam int SH_W   = ACC_W - lmsar_pkg::W_FRAC;
    localparam int EX_W   = 2*S + 1;
    localparam int EXF    = 2*(S-1);
    localparam int EX_SHR = (EXF >= lmsar_pkg::EX_FRAC) ? EXF - lmsar_pkg::EX_FRAC : 0;
    localparam int EX_SHL = (EXF >= lmsar_pkg::EX_FRAC) ? 0 : lmsar_pkg::EX_FRAC - EXF;
    localparam int X30_W  = lmsar_pkg::EX30_W;
    localparam int BP_W   = X30_W + lmsar_pkg::MU_BITS + 1;
    localparam int DL_W   = BP_W - lmsar_pkg::MU_RND_SHIFT;
    localparam int PW     = lmsar_pkg::PIDX_W;
    localparam int DW     = lmsar_pkg::DECAY_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DRAIN,
        ST_ROUND,
        ST_UPD,
        ST_DONE
    } t_state;

    t_state                             r_state;
    logic [CNT_W-1:0]                   r_cnt;
    logic [CW-1:0]                      r_order;
    logic [lmsar_pkg::MU_BITS-1:0]      r_mu;
    logic [DW-1:0]                      r_interval;
    logic [lmsar_pkg::TAPS_W-1:0]       r_taps;
    logic [PW-1:0]                      r_pidx;
    logic [DW-1:0]                      r_dcnt;
    logic                               r_adapt;
    logic                               r_decay;
    logic signed [S-1:0]                r_x;
    logic signed [S-1:0]                r_pred;
    logic signed [S:0]                  r_err;
    logic                               r_m_valid;
    logic [OUT_W-1:0]                   r_m_data;
    logic                               r_m_adapt;

    logic signed [PR_W-1:0]             r_prod;
    logic                               r_pact;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [EX_W-1:0]             r_a_ex;
    logic signed [WB-1:0]               r_a_w;
    logic signed [S-1:0]                r_a_x;
    logic                               r_a_act;
    logic signed [BP_W-1:0]             r_b_p;
    logic signed [WB-1:0]               r_b_w;
    logic signed [S-1:0]                r_b_x;
    logic                               r_b_act;

    logic signed [S-1:0]                c_x   [MAX_TAPS+1];
    logic signed [WB-1:0]               c_w   [MAX_TAPS+1];
    logic signed [S-1:0]                ins_x [MAX_TAPS];
    lmsar_pkg::t_cell_op                cell_op;

    logic [lmsar_pkg::MU_BITS-1:0]      dec_mu;
    logic                               out_free;
    logic                               in_fire;
    logic signed [S-1:0]                in_x;
    logic                               in_start;
    logic [CW-1:0]                      taps_e;
    logic [CW-1:0]                      acc_order;
    logic [PW-1:0]                      pidx_e;
    logic [DW-1:0]                      dcnt_e;
    logic [DW-1:0]                      interval_e;
    logic [DW:0]                        dcnt_inc;
    logic                               acc_adapt;
    logic signed [ACC_W-1:0]            rnd_sum;
    logic signed [SH_W-1:0]             rnd_sh;
    logic signed [S-1:0]                rnd_pred;
    logic signed [S:0]                  rnd_err;
    logic signed [63:0]                 ex_ext;
    logic signed [X30_W-1:0]            ex30;
    logic signed [BP_W-1:0]             upd_rnd;
    logic signed [DL_W-1:0]             upd_delta;
    logic signed [WB+1:0]               upd_sum;
    logic signed [WB-1:0]               upd_w;

    assign out_free = !r_m_valid || m_axis_tready;
    assign in_fire  = s_axis_tvalid && (r_state == ST_IDLE);
    assign in_x     = s_axis_tdata[S-1:0];
    assign in_start = s_axis_tuser[0];

    // sample acceptance bookkeeping
    always_comb begin
        taps_e = CW'(r_taps);
        if (taps_e == '0) begin
            acc_order = CW'(1);
        end else if (taps_e > CW'(MAX_TAPS)) begin
            acc_order = CW'(MAX_TAPS);
        end else begin
            acc_order = taps_e;
        end
        pidx_e     = in_start ? '0 : r_pidx;
        dcnt_e     = in_start ? '0 : r_dcnt;
        interval_e = (r_interval == '0) ? DW'(1) : r_interval;
        dcnt_inc   = (DW+1)'(dcnt_e) + (DW+1)'(1);
        acc_adapt  = pidx_e >= PW'(acc_order);
    end

    // prediction rounding and saturation
    always_comb begin
        rnd_sum = r_acc + ACC_W'(1 << (lmsar_pkg::W_FRAC - 1));
        rnd_sh  = SH_W'(rnd_sum >>> lmsar_pkg::W_FRAC);
        if ((&rnd_sh[SH_W-1:S-1]) || !(|rnd_sh[SH_W-1:S-1])) begin
            rnd_pred = rnd_sh[S-1:0];
        end else if (rnd_sh[SH_W-1]) begin
            rnd_pred = {1'b1, {(S-1){1'b0}}};
        end else begin
            rnd_pred = {1'b0, {(S-1){1'b1}}};
        end
        rnd_err = (S+1)'(r_x) - (S+1)'(rnd_pred);
    end

    // weight update tail of the loop
    always_comb begin
        ex_ext    = 64'(r_a_ex);
        ex30      = X30_W'((ex_ext >>> EX_SHR) <<< EX_SHL);
        upd_rnd   = r_b_p + BP_W'(1 << (lmsar_pkg::MU_RND_SHIFT - 1));
        upd_delta = DL_W'(upd_rnd >>> lmsar_pkg::MU_RND_SHIFT);
        upd_sum   = (WB+2)'(r_b_w) + (WB+2)'(upd_delta);
        if (!r_b_act) begin
            upd_w = r_b_w;
        end else if ((&upd_sum[WB+1:WB-1]) || !(|upd_sum[WB+1:WB-1])) begin
            upd_w = upd_sum[WB-1:0];
        end else if (upd_sum[WB+1]) begin
            upd_w = lmsar_pkg::W_MIN;
        end else begin
            upd_w = lmsar_pkg::W_MAX;
        end
    end

    always_comb begin
        case (r_state)
            ST_PRED:  cell_op = lmsar_pkg::CELL_ROTATE;
            ST_UPD:   cell_op = lmsar_pkg::CELL_ROTATE;
            ST_DONE:  cell_op = out_free ? lmsar_pkg::CELL_INSERT : lmsar_pkg::CELL_HOLD;
            default:  cell_op = lmsar_pkg::CELL_HOLD;
        endcase
    end

    assign c_x[MAX_TAPS] = (r_state == ST_UPD) ? r_b_x : c_x[0];
    assign c_w[MAX_TAPS] = (r_state == ST_UPD) ? upd_w : c_w[0];
    assign ins_x[0]      = r_x;

    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
        if (i > 0) begin : g_ins
            assign ins_x[i] = c_x[i-1];
        end
        lmsar_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_op     (cell_op),
            .i_next_x (c_x[i+1]),
            .i_next_w (c_w[i+1]),
            .i_prev_x (ins_x[i]),
            .o_x      (c_x[i]),
            .o_w      (c_w[i])
        );
    end

    lmsar_decay u_decay (
        .i_clk (i_clk),
        .i_mu  (r_mu),
        .o_mu  (dec_mu)
    );

    // shared multiply-accumulate and update pipeline
    always_ff @(posedge i_clk) begin
        r_prod  <= c_w[0] * c_x[0];
        r_pact  <= (r_state == ST_PRED) && (CW'(r_cnt) < r_order);
        if (r_state == ST_IDLE) begin
            r_acc <= '0;
        end else if ((r_state == ST_PRED || r_state == ST_DRAIN) && r_pact) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        r_a_ex  <= r_err * c_x[0];
        r_a_w   <= c_w[0];
        r_a_x   <= c_x[0];
        r_a_act <= (r_state == ST_UPD) && (CW'(r_cnt) < r_order);
        r_b_p   <= ex30 * $signed({1'b0, r_mu});
        r_b_w   <= r_a_w;
        r_b_x   <= r_a_x;
        r_b_act <= r_a_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_order    <= CW'(1);
            r_mu       <= lmsar_pkg::STEP_RST;
            r_interval <= lmsar_pkg::DECAY_RST;
            r_taps     <= lmsar_pkg::TAPS_RST;
            r_pidx     <= '0;
            r_dcnt     <= '0;
            r_adapt    <= 1'b0;
            r_decay    <= 1'b0;
            r_m_valid  <= 1'b0;
            r_m_adapt  <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && (r_state != ST_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_x     <= in_x;
                        r_order <= acc_order;
                        r_adapt <= acc_adapt;
                        r_decay <= acc_adapt && (dcnt_e == '0);
                        r_pidx  <= (pidx_e == {PW{1'b1}}) ? pidx_e : pidx_e + PW'(1);
                        r_dcnt  <= (dcnt_inc >= (DW+1)'(interval_e)) ? '0 : dcnt_inc[DW-1:0];
                        r_pred  <= '0;
                        r_err   <= '0;
                        r_cnt   <= '0;
                        r_state <= acc_adapt ? ST_PRED : ST_DONE;
                    end
                end
                ST_PRED: begin
                    if (r_cnt == CNT_W'(MAX_TAPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_pred  <= rnd_pred;
                    r_err   <= rnd_err;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (r_cnt == CNT_W'(MAX_TAPS + 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= OUT_W'({r_err, r_pred});
                        r_m_adapt <= r_adapt;
                        if (r_decay) begin
                            r_mu <= dec_mu;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lmsar_pkg::CFG_STEP_SIZE: r_mu       <= i_cfg_data[lmsar_pkg::MU_BITS-1:0];
                    lmsar_pkg::CFG_DECAY:     r_interval <= i_cfg_data[DW-1:0];
                    lmsar_pkg::CFG_TAPS:      r_taps     <= i_cfg_data[lmsar_pkg::TAPS_W-1:0];
                    default: begin
                        r_taps <= r_taps;
                    end
                endcase
            end
        end
    end

    assign s_axis_tready   = (r_state == ST_IDLE);
    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_adapt;

    // results without adaptation carry zero prediction and error
    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("non-adapted result with nonzero data");

    // the update rotation always follows a rounded prediction
    a_upd_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && $past(r_state) != ST_UPD) |-> ($past(r_state) == ST_ROUND))
        else $error("update loop entered without prediction");

    // one sample in flight at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second sample taken while one is in flight");

endmodule

// ===== tb/sv/tb_lms_autoregressive_predictor_top.sv =====
module tb_lms_autoregressive_predictor_top;

    localparam int MT = 16;
    localparam int SB = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam longint PRED_MAX = 32767;
    localparam longint PRED_MIN = -32768;
    localparam logic signed [SB-1:0] CORNER_SAMPLES [6] = '{
        16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'shc000
    };

    typedef enum int {
        WIDE,
        CORNERS,
        QUIET,
        SMOOTH
    } t_flavor;

    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 pass_start;
    } t_sample_item;

    typedef struct packed {
        logic signed [SB-1:0] prediction;
        logic signed [SB:0]   error;
        logic                 adapted;
    } t_prediction;

    logic            i_clk;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [15:0]     s_axis_tdata = '0;   // sample
    logic [0:0]      s_axis_tuser = '0;   // pass_start
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [39:0]     m_axis_tdata;        // prediction, error
    logic [0:0]      m_axis_tuser;        // adapted
    logic            i_cfg_we = 1'b0;
    logic [lmsar_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [lmsar_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    lms_autoregressive_predictor_top #(
        .MAX_TAPS    (MT),
        .SAMPLE_BITS (SB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    logic signed [SB-1:0] history [MT];
    logic signed [lmsar_pkg::W_BITS-1:0] weights [MT];
    logic [lmsar_pkg::MU_BITS-1:0]   mu_cur;
    logic [lmsar_pkg::DECAY_W-1:0]   decay_cfg;
    logic [lmsar_pkg::TAPS_W-1:0]    taps_cfg;
    int                   pass_count;
    int                   decay_pos;

    t_sample_item samples_to_send [$];
    t_prediction  predicted_results [$];
    t_sample_item offered;

    int src_idle_pct;
    int sink_idle_pct;
    int cycle_count;
    int fail_count;
    int samples_sent;
    int results_seen;
    int adapted_seen;
    int passes_queued;
    int settings_used;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic int order_of(logic [lmsar_pkg::TAPS_W-1:0] taps);
        if (taps == 0) return 1;
        if (taps > MT) return MT;
        return int'(taps);
    endfunction

    function automatic t_prediction predict_sample(t_sample_item it);
        t_prediction r;
        int order;
        int interval;
        longint acc;
        longint pred;
        longint err;
        longint ex;
        longint delta;
        longint w;
        r = '0;
        order = order_of(taps_cfg);
        interval = (decay_cfg == 0) ? 1 : int'(decay_cfg);
        if (it.pass_start) begin
            pass_count = 0;
            decay_pos = 0;
        end
        if (pass_count >= order) begin
            acc = 0;
            for (int k = 0; k < order; k++)
                acc += longint'(weights[k]) * longint'(history[k]);
            pred = (acc + (longint'(1) <<< (lmsar_pkg::W_FRAC - 1))) >>> lmsar_pkg::W_FRAC;
            if (pred > PRED_MAX) pred = PRED_MAX;
            if (pred < PRED_MIN) pred = PRED_MIN;
            err = longint'(it.sample) - pred;
            for (int k = 0; k < order; k++) begin
                ex = err * longint'(history[k]);
                delta = (ex * longint'(mu_cur) + (longint'(1) <<< 24)) >>> 25;
                w = longint'(weights[k]) + delta;
                if (w > longint'(lmsar_pkg::W_MAX)) w = longint'(lmsar_pkg::W_MAX);
                if (w < longint'(lmsar_pkg::W_MIN)) w = longint'(lmsar_pkg::W_MIN);
                weights[k] = w[lmsar_pkg::W_BITS-1:0];
            end
            if (decay_pos == 0)
                mu_cur = lmsar_pkg::MU_BITS'((longint'(mu_cur) * 100 + 50) / 101);
            r.prediction = pred[SB-1:0];
            r.error = err[SB:0];
            r.adapted = 1'b1;
        end
        decay_pos++;
        if (decay_pos >= interval) decay_pos = 0;
        for (int k = MT - 1; k > 0; k--)
            history[k] = history[k-1];
        history[0] = it.sample;
        if (pass_count < 65535) pass_count++;
        return r;
    endfunction

    // sample source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_results.insert(predicted_results.size(), predict_sample(offered));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    offered = samples_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= offered.sample;
                    s_axis_tuser <= offered.pass_start;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin : result_check
        t_prediction want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser[0]) adapted_seen++;
                if (predicted_results.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (m_axis_tdata[15:0] !== want.prediction) begin
                        $error("prediction: expected %0d, got %0d",
                               want.prediction, $signed(m_axis_tdata[15:0]));
                        fail_count++;
                    end
                    if (m_axis_tdata[32:16] !== want.error) begin
                        $error("error: expected %0d, got %0d",
                               want.error, $signed(m_axis_tdata[32:16]));
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== want.adapted) begin
                        $error("adapted: expected %0d, got %0d", want.adapted, m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic queue_item(input logic signed [SB-1:0] value, input logic fresh);
        t_sample_item it;
        it.sample = value;
        it.pass_start = fresh;
        samples_to_send.insert(samples_to_send.size(), it);
    endtask

    task automatic queue_pass(input int len, input t_flavor flavor, input bit fresh);
        int p1;
        int p2;
        int v;
        int noise;
        p1 = int'($urandom_range(0, 16000)) - 8000;
        p2 = p1;
        for (int n = 0; n < len; n++) begin
            noise = int'($urandom_range(0, 256)) - 128;
            case (flavor)
                WIDE:    v = int'($urandom_range(0, 65535)) - 32768;
                CORNERS: v = int'(CORNER_SAMPLES[$urandom_range(0, 5)]);
                QUIET:   v = int'($urandom_range(0, 1024)) - 512;
                default: v = (29 * p1 - 14 * p2) / 16 + noise;
            endcase
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            p2 = p1;
            p1 = v;
            queue_item(v[SB-1:0], fresh && n == 0);
        end
        if (fresh) passes_queued++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (samples_to_send.size() > 0 || s_axis_tvalid || predicted_results.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [lmsar_pkg::MU_BITS-1:0] mu_val,
                                 input logic [lmsar_pkg::DECAY_W-1:0] decay_val,
                                 input logic [lmsar_pkg::TAPS_W-1:0] taps_val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= lmsar_pkg::CFG_STEP_SIZE;
        i_cfg_data <= mu_val;
        @(posedge i_clk);
        i_cfg_idx <= lmsar_pkg::CFG_DECAY;
        i_cfg_data <= lmsar_pkg::CFG_DATA_W'(decay_val);
        @(posedge i_clk);
        i_cfg_idx <= lmsar_pkg::CFG_TAPS;
        i_cfg_data <= lmsar_pkg::CFG_DATA_W'(taps_val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mu_cur = mu_val;
        decay_cfg = decay_val;
        taps_cfg = taps_val;
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic run_random_passes(input int target);
        int count;
        int eff;
        int len;
        count = 0;
        while (count < target) begin
            eff = order_of(taps_cfg);
            if ($urandom_range(0, 4) == 0)
                len = int'($urandom_range(1, eff));
            else
                len = eff + int'($urandom_range(1, 40));
            queue_pass(len, t_flavor'($urandom_range(0, 3)), $urandom_range(0, 9) != 0);
            count += len;
        end
        wait_drained();
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("timed out after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        for (int k = 0; k < MT; k++) begin
            history[k] = '0;
            weights[k] = '0;
        end
        mu_cur = lmsar_pkg::STEP_RST;
        decay_cfg = lmsar_pkg::DECAY_RST;
        taps_cfg = lmsar_pkg::TAPS_RST;
        pass_count = 0;
        decay_pos = 0;
        src_idle_pct = 20;
        sink_idle_pct = 60;
        fail_count = 0;
        samples_sent = 0;
        results_seen = 0;
        adapted_seen = 0;
        passes_queued = 0;
        settings_used = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // implicit first pass after reset, reset settings
        for (int n = 0; n < 17; n++)
            queue_item(CORNER_SAMPLES[n % 6], 1'b0);
        wait_drained();

        // largest step, decay on every adapted sample, single tap, restart mid pass
        load_settings('1, '0, 5'd1);
        for (int n = 0; n < 8; n++)
            queue_item((n % 2) ? 16'sh8000 : 16'sh7fff, n == 0 || n == 5);
        wait_drained();

        load_settings(lmsar_pkg::STEP_RST, lmsar_pkg::DECAY_RST, lmsar_pkg::TAPS_RST);
        run_random_passes(100);
        load_settings('0, 16'd1, 5'd4);
        run_random_passes(100);

        src_idle_pct = 60;
        sink_idle_pct = 20;
        load_settings(lmsar_pkg::MU_BITS'($urandom), 16'hffff, 5'd31);
        run_random_passes(100);
        load_settings(24'h0fffff, 16'd3, 5'd0);
        run_random_passes(100);
        load_settings('1, 16'd7, 5'd17);
        run_random_passes(100);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        load_settings(24'd1, 16'd2, 5'd8);
        run_random_passes(100);
        load_settings(lmsar_pkg::MU_BITS'($urandom),
                      lmsar_pkg::DECAY_W'($urandom_range(1, 40)),
                      lmsar_pkg::TAPS_W'($urandom_range(1, MT)));
        run_random_passes(100);
        load_settings(lmsar_pkg::MU_BITS'($urandom), lmsar_pkg::DECAY_W'($urandom),
                      lmsar_pkg::TAPS_W'($urandom));
        run_random_passes(100);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d samples in %0d started passes under %0d register settings",
                 samples_sent, passes_queued, settings_used);
        $display("%0d results checked, %0d of them adapted", results_seen, adapted_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
